FILE: hdl/assert_macros.svh
// Assertion macros shared by the RTL of the steering block.
// Bodies are empty when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define PPS_ASSERT_IMP(lbl, ant, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |-> (cons)) \
        else $error("assertion failed");
`define PPS_ASSERT_NXT(lbl, ant, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |=> (cons)) \
        else $error("assertion failed");
`else
`define PPS_ASSERT_IMP(lbl, ant, cons)
`define PPS_ASSERT_NXT(lbl, ant, cons)
`endif
`endif

FILE: hdl/pps_pkg.sv
// Types, constants and the arctangent table of the steering block.
// No dependencies.
package pps_pkg;

    localparam int MAX_POINTS_DEF   = 128;
    localparam int CORDIC_STEPS_DEF = 16;

    localparam int XW   = 24;
    localparam int SQW  = 25;
    localparam int D2W  = 50;
    localparam int RMW  = 29;
    localparam int CXW  = 36;
    localparam int ZW   = 26;
    localparam int AQW  = 17;
    localparam int CNTW = 5;
    localparam int CFGW = 23;
    localparam int RIW  = 3;

    localparam logic signed [ZW-1:0] ANG_PI     = 26'sd3294199;
    localparam logic signed [ZW-1:0] ANG_TWO_PI = 26'sd6588398;

    localparam logic [22:0] LOOKAHEAD_RST = 23'd7680;
    localparam logic [14:0] MAX_STEER_RST = 15'd4915;
    localparam logic [15:0] TOP_SPEED_RST = 16'd7680;
    localparam logic [15:0] ANG_GAIN_RST  = 16'd6554;
    localparam logic [15:0] DST_GAIN_RST  = 16'd6554;
    localparam logic [15:0] IDX_RATE_RST  = 16'd2560;

    typedef enum logic [RIW-1:0] {
        REG_LOOKAHEAD = 3'd0,
        REG_MAX_STEER = 3'd1,
        REG_TOP_SPEED = 3'd2,
        REG_ANG_GAIN  = 3'd3,
        REG_DST_GAIN  = 3'd4,
        REG_IDX_RATE  = 3'd5
    } t_reg;

    typedef enum logic [3:0] {
        S_IDLE, S_LA, S_RD, S_LOAD, S_SQ, S_CMP, S_SQRT, S_ADV,
        S_FRD, S_FLOAD, S_CORD, S_WRAP, S_GAIN, S_SPD
    } t_state;

    function automatic logic signed [ZW-1:0] atan_q20(input logic [CNTW-1:0] i);
        logic signed [ZW-1:0] v;
        case (i)
            5'd0:  v = 26'sd823550;
            5'd1:  v = 26'sd486170;
            5'd2:  v = 26'sd256879;
            5'd3:  v = 26'sd130396;
            5'd4:  v = 26'sd65451;
            5'd5:  v = 26'sd32757;
            5'd6:  v = 26'sd16383;
            5'd7:  v = 26'sd8192;
            5'd8:  v = 26'sd4096;
            5'd9:  v = 26'sd2048;
            5'd10: v = 26'sd1024;
            5'd11: v = 26'sd512;
            5'd12: v = 26'sd256;
            5'd13: v = 26'sd128;
            5'd14: v = 26'sd64;
            5'd15: v = 26'sd32;
            5'd16: v = 26'sd16;
            5'd17: v = 26'sd8;
            5'd18: v = 26'sd4;
            5'd19: v = 26'sd2;
            5'd20: v = 26'sd1;
            default: v = 26'sd0;
        endcase
        return v;
    endfunction

endpackage

FILE: hdl/pure_pursuit_steering.sv
// Pure pursuit steering controller: path store, nearest point scan, sqrt, CORDIC.
// Depends on pps_pkg, pps_ram and assert_macros.svh.
//
// An append word leaves busy low. A query on a stored path squares the lookahead,
// then reads, loads, squares and compares each stored point, takes the square root,
// picks the focus point, runs the CORDIC steps and applies the gains. It stays busy
// throughout and shows its result in the cycle after, when the next word may already
// be taken (the CORDIC steps are skipped when the focus point equals the vehicle
// position). The lookahead square and each point's squared distance come from a bit
// serial squarer, one multiplier bit per cycle, and the square root retires one
// result bit per cycle. A query on an empty path answers with status set and busy
// low. The result is shown for one cycle with o_strobe and must be taken then.
`include "assert_macros.svh"
module pure_pursuit_steering #(
    parameter int MAX_POINTS   = pps_pkg::MAX_POINTS_DEF,
    parameter int CORDIC_STEPS = pps_pkg::CORDIC_STEPS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       i_kind,
    input  logic                       i_start_new,
    input  logic signed [23:0]         i_pos_x,
    input  logic signed [23:0]         i_pos_y,
    input  logic signed [15:0]         i_heading,
    input  logic [15:0]                i_speed,
    input  logic                       i_cfg_we,
    input  logic [pps_pkg::RIW-1:0]    i_cfg_addr,
    input  logic [pps_pkg::CFGW-1:0]   i_cfg_wdata,
    output logic                       o_strobe,
    output logic signed [15:0]         o_steer_angle,
    output logic [15:0]                o_target_speed,
    output logic [6:0]                 o_focus_index,
    output logic                       o_status
);
    localparam int AW  = $clog2(MAX_POINTS);
    localparam int CW  = $clog2(MAX_POINTS + 1);
    localparam int LW  = ((CW > 16) ? CW : 16) + 1;
    localparam int XW  = pps_pkg::XW;
    localparam int SQW = pps_pkg::SQW;
    localparam int D2W = pps_pkg::D2W;
    localparam int RMW = pps_pkg::RMW;
    localparam int CXW = pps_pkg::CXW;
    localparam int ZW  = pps_pkg::ZW;
    localparam int AQW = pps_pkg::AQW;
    localparam int CNTW = pps_pkg::CNTW;

    pps_pkg::t_state r_state, n_state;

    logic [22:0] r_lookahead;
    logic [14:0] r_max_steer;
    logic [15:0] r_top_speed, r_ang_gain, r_dst_gain, r_idx_rate;

    logic [CW-1:0]  r_count, n_count;
    logic [AW-1:0]  r_idx, n_idx, r_best, n_best;
    logic [CNTW-1:0] r_cnt, n_cnt;

    logic signed [XW-1:0] r_px, n_px, r_py, n_py;
    logic signed [15:0]   r_yaw, n_yaw;
    logic [15:0]          r_adv, n_adv;

    logic [D2W-1:0] r_sqa_x, n_sqa_x, r_sqa_y, n_sqa_y;
    logic [SQW-1:0] r_sqb_x, n_sqb_x, r_sqb_y, n_sqb_y;
    logic [D2W-1:0] r_acc_x, n_acc_x, r_acc_y, n_acc_y;
    logic [D2W-1:0] r_la2, n_la2, r_best_d2, n_best_d2;

    logic [D2W-1:0] r_sqv, n_sqv;
    logic [RMW-1:0] r_rem, n_rem;
    logic [SQW-1:0] r_root, n_root;

    logic signed [CXW-1:0] r_cx, n_cx, r_cy, n_cy;
    logic signed [ZW-1:0]  r_cz, n_cz;
    logic signed [AQW-1:0] r_aq, n_aq;
    logic [31:0]           r_reda, n_reda;
    logic [40:0]           r_redd, n_redd;

    logic               r_strobe, n_strobe;
    logic signed [15:0] r_steer, n_steer;
    logic [15:0]        r_tspeed, n_tspeed;
    logic               r_status, n_status;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [2*XW-1:0] ram_rdata;
    logic signed [XW-1:0] mem_x, mem_y;

    pps_ram #(.WIDTH(2 * XW), .DEPTH(MAX_POINTS)) u_path (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata({i_pos_x, i_pos_y}),
        .i_raddr(r_idx),
        .o_rdata(ram_rdata)
    );

    assign mem_x = ram_rdata[2*XW-1:XW];
    assign mem_y = ram_rdata[XW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lookahead <= pps_pkg::LOOKAHEAD_RST;
            r_max_steer <= pps_pkg::MAX_STEER_RST;
            r_top_speed <= pps_pkg::TOP_SPEED_RST;
            r_ang_gain  <= pps_pkg::ANG_GAIN_RST;
            r_dst_gain  <= pps_pkg::DST_GAIN_RST;
            r_idx_rate  <= pps_pkg::IDX_RATE_RST;
        end else if (i_cfg_we) begin
            unique case (pps_pkg::t_reg'(i_cfg_addr))
                pps_pkg::REG_LOOKAHEAD: r_lookahead <= i_cfg_wdata;
                pps_pkg::REG_MAX_STEER: r_max_steer <= i_cfg_wdata[14:0];
                pps_pkg::REG_TOP_SPEED: r_top_speed <= i_cfg_wdata[15:0];
                pps_pkg::REG_ANG_GAIN:  r_ang_gain  <= i_cfg_wdata[15:0];
                pps_pkg::REG_DST_GAIN:  r_dst_gain  <= i_cfg_wdata[15:0];
                pps_pkg::REG_IDX_RATE:  r_idx_rate  <= i_cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= pps_pkg::S_IDLE;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_strobe <= n_strobe;
        end
        r_idx <= n_idx;       r_best <= n_best;     r_cnt <= n_cnt;
        r_px <= n_px;         r_py <= n_py;         r_yaw <= n_yaw;
        r_adv <= n_adv;
        r_sqa_x <= n_sqa_x;   r_sqa_y <= n_sqa_y;
        r_sqb_x <= n_sqb_x;   r_sqb_y <= n_sqb_y;
        r_acc_x <= n_acc_x;   r_acc_y <= n_acc_y;
        r_la2 <= n_la2;       r_best_d2 <= n_best_d2;
        r_sqv <= n_sqv;       r_rem <= n_rem;       r_root <= n_root;
        r_cx <= n_cx;         r_cy <= n_cy;         r_cz <= n_cz;
        r_aq <= n_aq;         r_reda <= n_reda;     r_redd <= n_redd;
        r_steer <= n_steer;   r_tspeed <= n_tspeed; r_status <= n_status;
    end

    always_comb begin
        logic [CW-1:0]        base;
        logic [31:0]          prod;
        logic signed [SQW-1:0] dx, dy;
        logic [D2W-1:0]       d2;
        logic [RMW-1:0]       rem2, trial;
        logic [LW-1:0]        lim;
        logic signed [SQW:0]  lx, ly;
        logic signed [CXW-1:0] xs, ys;
        logic signed [ZW-1:0] v;
        logic signed [ZW-1:0] alpha;
        logic signed [AQW-1:0] ms;
        logic [15:0]          mag;
        logic [47:0]          red, top;

        n_state = r_state;     n_count = r_count;   n_strobe = 1'b0;
        n_idx = r_idx;         n_best = r_best;     n_cnt = r_cnt;
        n_px = r_px;           n_py = r_py;         n_yaw = r_yaw;
        n_adv = r_adv;
        n_sqa_x = r_sqa_x;     n_sqa_y = r_sqa_y;
        n_sqb_x = r_sqb_x;     n_sqb_y = r_sqb_y;
        n_acc_x = r_acc_x;     n_acc_y = r_acc_y;
        n_la2 = r_la2;         n_best_d2 = r_best_d2;
        n_sqv = r_sqv;         n_rem = r_rem;       n_root = r_root;
        n_cx = r_cx;           n_cy = r_cy;         n_cz = r_cz;
        n_aq = r_aq;           n_reda = r_reda;     n_redd = r_redd;
        n_steer = r_steer;     n_tspeed = r_tspeed; n_status = r_status;
        ram_we = 1'b0;
        base = i_start_new ? '0 : r_count;
        ram_waddr = AW'(base);
        prod = i_speed * r_idx_rate;
        dx = SQW'(r_px) - SQW'(mem_x);
        dy = SQW'(r_py) - SQW'(mem_y);
        d2 = r_acc_x + r_acc_y;
        rem2 = {r_rem[RMW-3:0], r_sqv[D2W-1:D2W-2]};
        trial = RMW'({r_root, 2'b01});
        lim = LW'(r_best) + LW'(r_adv);
        lx = '0;
        ly = '0;
        xs = r_cx >>> r_cnt;
        ys = r_cy >>> r_cnt;
        v = '0;
        alpha = '0;
        ms = AQW'(signed'({2'b00, r_max_steer}));
        mag = '0;
        red = '0;
        top = '0;

        unique case (r_state) inside
            pps_pkg::S_IDLE: begin
                if (start) begin
                    n_px = i_pos_x;
                    n_py = i_pos_y;
                    n_yaw = i_heading;
                    n_adv = prod[31:16];
                    if (!i_kind) begin
                        if (base < CW'(MAX_POINTS)) begin
                            ram_we = 1'b1;
                            n_count = base + CW'(1);
                        end else begin
                            n_count = base;
                        end
                    end else if (r_count == '0) begin
                        n_strobe = 1'b1;
                        n_steer = '0;
                        n_tspeed = '0;
                        n_idx = '0;
                        n_status = 1'b1;
                    end else begin
                        n_sqa_x = D2W'(r_lookahead);
                        n_sqb_x = SQW'(r_lookahead);
                        n_sqa_y = '0;
                        n_sqb_y = '0;
                        n_acc_x = '0;
                        n_acc_y = '0;
                        n_cnt = '0;
                        n_state = pps_pkg::S_LA;
                    end
                end
            end
            pps_pkg::S_LA, pps_pkg::S_SQ: begin
                if (r_sqb_x[0]) n_acc_x = r_acc_x + r_sqa_x;
                if (r_sqb_y[0]) n_acc_y = r_acc_y + r_sqa_y;
                n_sqa_x = r_sqa_x << 1;
                n_sqa_y = r_sqa_y << 1;
                n_sqb_x = r_sqb_x >> 1;
                n_sqb_y = r_sqb_y >> 1;
                n_cnt = r_cnt + CNTW'(1);
                if (r_cnt == CNTW'(SQW - 1)) begin
                    if (r_state == pps_pkg::S_LA) begin
                        n_la2 = n_acc_x;
                        n_idx = '0;
                        n_state = pps_pkg::S_RD;
                    end else begin
                        n_state = pps_pkg::S_CMP;
                    end
                end
            end
            pps_pkg::S_RD: begin
                n_state = pps_pkg::S_LOAD;
            end
            pps_pkg::S_LOAD: begin
                n_sqa_x = D2W'(unsigned'(dx[SQW-1] ? -dx : dx));
                n_sqb_x = dx[SQW-1] ? -dx : dx;
                n_sqa_y = D2W'(unsigned'(dy[SQW-1] ? -dy : dy));
                n_sqb_y = dy[SQW-1] ? -dy : dy;
                n_acc_x = '0;
                n_acc_y = '0;
                n_cnt = '0;
                n_state = pps_pkg::S_SQ;
            end
            pps_pkg::S_CMP: begin
                if (r_idx == '0 || d2 < r_best_d2) begin
                    n_best_d2 = d2;
                    n_best = r_idx;
                end
                if (CW'(r_idx) == r_count - CW'(1)) begin
                    n_sqv = n_best_d2;
                    n_rem = '0;
                    n_root = '0;
                    n_cnt = '0;
                    n_state = pps_pkg::S_SQRT;
                end else begin
                    n_idx = r_idx + AW'(1);
                    n_state = pps_pkg::S_RD;
                end
            end
            pps_pkg::S_SQRT: begin
                if (rem2 >= trial) begin
                    n_rem = rem2 - trial;
                    n_root = {r_root[SQW-2:0], 1'b1};
                end else begin
                    n_rem = rem2;
                    n_root = {r_root[SQW-2:0], 1'b0};
                end
                n_sqv = r_sqv << 2;
                n_cnt = r_cnt + CNTW'(1);
                if (r_cnt == CNTW'(SQW - 1)) n_state = pps_pkg::S_ADV;
            end
            pps_pkg::S_ADV: begin
                n_idx = r_best;
                if (r_best_d2 > r_la2) begin
                    if (lim >= LW'(r_count)) n_idx = AW'(r_count - CW'(1));
                    else n_idx = AW'(lim);
                end
                n_state = pps_pkg::S_FRD;
            end
            pps_pkg::S_FRD: begin
                n_state = pps_pkg::S_FLOAD;
            end
            pps_pkg::S_FLOAD: begin
                lx = -(SQW + 1)'(dx);
                ly = -(SQW + 1)'(dy);
                n_cnt = '0;
                if (dx == '0 && dy == '0) begin
                    n_cz = '0;
                    n_state = pps_pkg::S_WRAP;
                end else begin
                    if (lx[SQW]) begin
                        n_cz = (ly >= 0) ? pps_pkg::ANG_PI : -pps_pkg::ANG_PI;
                        lx = -lx;
                        ly = -ly;
                    end else begin
                        n_cz = '0;
                    end
                    n_cx = CXW'(lx) <<< 8;
                    n_cy = CXW'(ly) <<< 8;
                    n_state = pps_pkg::S_CORD;
                end
            end
            pps_pkg::S_CORD: begin
                if (r_cy > 0) begin
                    n_cx = r_cx + ys;
                    n_cy = r_cy - xs;
                    n_cz = r_cz + pps_pkg::atan_q20(r_cnt);
                end else begin
                    n_cx = r_cx - ys;
                    n_cy = r_cy + xs;
                    n_cz = r_cz - pps_pkg::atan_q20(r_cnt);
                end
                n_cnt = r_cnt + CNTW'(1);
                if (r_cnt == CNTW'(CORDIC_STEPS - 1)) n_state = pps_pkg::S_WRAP;
            end
            pps_pkg::S_WRAP: begin
                v = r_cz - (ZW'(r_yaw) <<< 7) + pps_pkg::ANG_PI;
                if (v < 0) v = v + pps_pkg::ANG_TWO_PI;
                else if (v >= pps_pkg::ANG_TWO_PI) v = v - pps_pkg::ANG_TWO_PI;
                alpha = v - pps_pkg::ANG_PI + ZW'(64);
                n_aq = AQW'(alpha >>> 7);
                n_state = pps_pkg::S_GAIN;
            end
            pps_pkg::S_GAIN: begin
                if (r_aq > ms) n_steer = 16'(ms);
                else if (r_aq < -ms) n_steer = 16'(-ms);
                else n_steer = 16'(r_aq);
                mag = 16'(r_aq[AQW-1] ? -r_aq : r_aq);
                n_reda = r_ang_gain * mag;
                n_redd = r_dst_gain * r_root;
                n_state = pps_pkg::S_SPD;
            end
            pps_pkg::S_SPD: begin
                red = 48'(r_reda) + (48'(r_redd) << 5);
                top = 48'(r_top_speed) << 21;
                n_tspeed = (top > red) ? 16'((top - red) >> 21) : '0;
                n_status = 1'b0;
                n_strobe = 1'b1;
                n_state = pps_pkg::S_IDLE;
            end
            default: n_state = pps_pkg::S_IDLE;
        endcase
    end

    assign busy           = (r_state != pps_pkg::S_IDLE);
    assign o_strobe       = r_strobe;
    assign o_steer_angle  = r_steer;
    assign o_target_speed = r_tspeed;
    assign o_focus_index  = 7'(r_idx);
    assign o_status       = r_status;

    `PPS_ASSERT_IMP(a_count_max, 1'b1, r_count <= CW'(MAX_POINTS))
    `PPS_ASSERT_IMP(a_empty_zero, o_strobe && o_status, o_steer_angle == 16'sd0 && o_focus_index == 7'd0)
    `PPS_ASSERT_IMP(a_steer_clamp, o_strobe, o_steer_angle <= $signed({1'b0, r_max_steer}) && o_steer_angle >= -$signed({1'b0, r_max_steer}))
    `PPS_ASSERT_IMP(a_ok_from_spd, o_strobe && !o_status, $past(r_state) == pps_pkg::S_SPD)
    `PPS_ASSERT_NXT(a_spd_strobe, r_state == pps_pkg::S_SPD, o_strobe && !busy)
endmodule

FILE: hdl/pps_ram.sv
// Generic single write port RAM with a registered read port.
// No dependencies.
module pps_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: verif/tb_pure_pursuit_steering.sv
// Self-checking testbench for pure_pursuit_steering: directed table, then random path phases.
// Predicts query results by an in-bench model or a typed row; depends on pps_pkg and the RTL.
module tb_pure_pursuit_steering;

    localparam int        DEPTH       = 128;
    localparam int        STEPS       = 16;
    localparam longint    PI_Q20      = 3294199;
    localparam longint    TWO_PI_Q20  = 6588398;
    localparam int        TARGET_ITEMS = 1400;
    localparam longint    CYCLE_LIMIT = 20000000;

    typedef struct packed {
        logic signed [15:0] steer;
        logic [15:0]        speed;
        logic [6:0]         focus;
        logic               status;
    } t_steer_word;

    typedef struct {
        bit                 kind;
        bit                 start_new;
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic signed [15:0] heading;
        logic [15:0]        speed;
        bit                 typed;
        t_steer_word        want;
    } t_stim_row;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          start;
    logic                          busy;
    logic                          i_kind;
    logic                          i_start_new;
    logic signed [23:0]            i_pos_x;
    logic signed [23:0]            i_pos_y;
    logic signed [15:0]            i_heading;
    logic [15:0]                   i_speed;
    logic                          i_cfg_we;
    logic [pps_pkg::RIW-1:0]       i_cfg_addr;
    logic [pps_pkg::CFGW-1:0]      i_cfg_wdata;
    logic                          o_strobe;
    logic signed [15:0]            o_steer_angle;
    logic [15:0]                   o_target_speed;
    logic [6:0]                    o_focus_index;
    logic                          o_status;

    pure_pursuit_steering DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_kind(i_kind), .i_start_new(i_start_new), .i_pos_x(i_pos_x),
        .i_pos_y(i_pos_y), .i_heading(i_heading), .i_speed(i_speed),
        .i_cfg_we(i_cfg_we), .i_cfg_addr(i_cfg_addr), .i_cfg_wdata(i_cfg_wdata),
        .o_strobe(o_strobe), .o_steer_angle(o_steer_angle),
        .o_target_speed(o_target_speed), .o_focus_index(o_focus_index),
        .o_status(o_status)
    );

    longint      path_x [DEPTH];
    longint      path_y [DEPTH];
    int          path_len;
    longint      la_dist, steer_lim, speed_top, gain_ang, gain_dst, rate_idx;
    longint      atan_q20 [STEPS] = '{823550, 486170, 256879, 130396, 65451, 32757,
                                      16383, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32};

    t_steer_word steer_q[$];
    t_stim_row   dir_tab[$];
    bit          row_typed;
    t_steer_word row_want;
    int          word_cnt;
    int          err_cnt;
    int          items;
    longint      cycles;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic longint unsigned sqrt_floor(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint bearing_q20(longint dy, longint dx);
        longint z, xs, ys;
        z = 0;
        if (dx == 0 && dy == 0) return 0;
        if (dx < 0) begin
            z  = (dy >= 0) ? PI_Q20 : -PI_Q20;
            dx = -dx;
            dy = -dy;
        end
        dx = dx * 256;
        dy = dy * 256;
        for (int i = 0; i < STEPS; i++) begin
            xs = dx >>> i;
            ys = dy >>> i;
            if (dy > 0) begin
                dx = dx + ys; dy = dy - xs; z = z + atan_q20[i];
            end else begin
                dx = dx - ys; dy = dy + xs; z = z - atan_q20[i];
            end
        end
        return z;
    endfunction

    // Advance path state; return 1 with the steering word when a query.
    function automatic bit steer_predict(bit kind, bit sn, longint px, longint py,
                                         longint yaw, longint spd, output t_steer_word w);
        longint          dx, dy, alpha, aq, st;
        longint unsigned d2, best_d2, near_d, lim, red, top;
        int              best, focus;
        w = '0;
        best = 0;
        best_d2 = 0;
        if (!kind) begin
            if (sn) path_len = 0;
            if (path_len < DEPTH) begin
                path_x[path_len] = px;
                path_y[path_len] = py;
                path_len++;
            end
            return 1'b0;
        end
        if (path_len == 0) begin
            w.status = 1'b1;
            return 1'b1;
        end
        for (int i = 0; i < path_len; i++) begin
            dx = px - path_x[i];
            dy = py - path_y[i];
            d2 = dx * dx + dy * dy;
            if (i == 0 || d2 < best_d2) begin
                best_d2 = d2;
                best = i;
            end
        end
        near_d = sqrt_floor(best_d2);
        focus = best;
        if (best_d2 > la_dist * la_dist) begin
            lim = best + ((spd * rate_idx) >> 16);
            if (lim >= path_len) lim = path_len - 1;
            focus = int'(lim);
        end
        alpha = bearing_q20(path_y[focus] - py, path_x[focus] - px) - yaw * 128;
        alpha = (alpha + PI_Q20) % TWO_PI_Q20;
        if (alpha < 0) alpha = alpha + TWO_PI_Q20;
        alpha = alpha - PI_Q20;
        aq = (alpha + 64) >>> 7;
        st = aq;
        if (st > steer_lim) st = steer_lim;
        if (st < -steer_lim) st = -steer_lim;
        red = gain_ang * ((aq < 0) ? -aq : aq) + ((gain_dst * near_d) << 5);
        top = speed_top << 21;
        top = (top > red) ? ((top - red) >> 21) : 0;
        w.steer  = st[15:0];
        w.speed  = top[15:0];
        w.focus  = focus[6:0];
        w.status = 1'b0;
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin
        t_steer_word w, got;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else if (i_rst_n) begin
            if (o_strobe) begin
                got = '{o_steer_angle, o_target_speed, o_focus_index, o_status};
                if (steer_q.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= 10) $display("unexpected word %p", got);
                end else begin
                    w = steer_q.pop_front();
                    if (got !== w) begin
                        err_cnt++;
                        if (err_cnt <= 10) $display("mismatch: expected %p actual %p", w, got);
                    end
                end
            end
            if (start && !busy) begin
                if (steer_predict(i_kind, i_start_new, i_pos_x, i_pos_y, i_heading,
                                  i_speed, w))
                    steer_q.push_back(row_typed ? row_want : w);
                word_cnt++;
            end
        end
    end

    task automatic send_word(bit kind, bit sn, logic signed [23:0] x, logic signed [23:0] y,
                             logic signed [15:0] h, logic [15:0] spd);
        int target, gap;
        i_kind = kind; i_start_new = sn; i_pos_x = x; i_pos_y = y;
        i_heading = h; i_speed = spd;
        start = 1'b1;
        target = word_cnt + 1;
        do @(negedge i_clk); while (word_cnt != target);
        items++;
        row_typed = 1'b0;
        case ($urandom_range(0, 9)) inside
            [0:5]:   gap = 0;
            [6:8]:   gap = $urandom_range(1, 3);
            default: gap = $urandom_range(5, 40);
        endcase
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic wait_idle();
        start = 1'b0;
        while (steer_q.size() != 0 || busy) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic set_reg(pps_pkg::t_reg r, longint v);
        i_cfg_we = 1'b1;
        i_cfg_addr = r;
        i_cfg_wdata = v[pps_pkg::CFGW-1:0];
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (r)
            pps_pkg::REG_LOOKAHEAD: la_dist   = v;
            pps_pkg::REG_MAX_STEER: steer_lim = v;
            pps_pkg::REG_TOP_SPEED: speed_top = v;
            pps_pkg::REG_ANG_GAIN:  gain_ang  = v;
            pps_pkg::REG_DST_GAIN:  gain_dst  = v;
            pps_pkg::REG_IDX_RATE:  rate_idx  = v;
            default: ;
        endcase
    endtask

    function automatic longint pick(longint hi);
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return hi;
            default: return $urandom_range(0, int'(hi));
        endcase
    endfunction

    function automatic void add_row(bit kind, bit sn, int x, int y, int h, int spd,
                                    bit typed, t_steer_word want);
        t_stim_row r;
        r = '{kind, sn, x[23:0], y[23:0], h[15:0], spd[15:0], typed, want};
        dir_tab.push_back(r);
    endfunction

    initial begin
        int n, q, k, step, off;
        bit wide;
        int big_cnt, phase;
        longint cx, cy;
        logic signed [23:0] qx, qy;
        logic [15:0] spd;

        start = 1'b0; i_kind = 1'b0; i_start_new = 1'b0; i_pos_x = '0; i_pos_y = '0;
        i_heading = '0; i_speed = '0; i_cfg_we = 1'b0; i_cfg_addr = '0; i_cfg_wdata = '0;
        i_rst_n = 1'b0;
        row_typed = 1'b0; row_want = '0;
        word_cnt = 0; err_cnt = 0; items = 0; cycles = 0; big_cnt = 0;
        path_len = 0;
        la_dist = 7680; steer_lim = 4915; speed_top = 7680;
        gain_ang = 6554; gain_dst = 6554; rate_idx = 2560;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        add_row(1, 0, 0, 0, 0, 0, 1, '{16'sd0, 16'd0, 7'd0, 1'b1});
        add_row(1, 1, 8388607, -8388608, 32767, 65535, 1, '{16'sd0, 16'd0, 7'd0, 1'b1});
        add_row(0, 1, 0, 0, 0, 0, 0, '0);
        add_row(1, 0, 0, 0, 0, 0, 1, '{16'sd0, 16'd7680, 7'd0, 1'b0});
        add_row(1, 1, 0, 0, -32768, 65535, 0, '0);
        add_row(0, 1, 8388607, -8388608, 0, 0, 0, '0);
        add_row(0, 0, -8388608, 8388607, 0, 0, 0, '0);
        add_row(1, 0, 0, 0, 32767, 65535, 0, '0);
        add_row(1, 0, 8388607, -8388608, -32768, 0, 0, '0);
        add_row(1, 0, -8388608, -8388608, 12345, 256, 0, '0);
        add_row(0, 1, 0, 0, 0, 0, 0, '0);
        for (int i = 1; i < 8; i++) add_row(0, 0, i * 2560, i * 512, 0, 0, 0, '0);
        add_row(1, 0, -25600, 0, 0, 0, 0, '0);
        add_row(1, 0, -25600, 0, 0, 64, 0, '0);
        add_row(1, 0, -25600, 100, -12000, 65535, 0, '0);
        add_row(1, 0, 7680, 1536, 0, 300, 0, '0);
        add_row(1, 0, 30000, -30000, 25000, 512, 0, '0);
        foreach (dir_tab[i]) begin
            row_typed = dir_tab[i].typed;
            row_want  = dir_tab[i].want;
            send_word(dir_tab[i].kind, dir_tab[i].start_new, dir_tab[i].x, dir_tab[i].y,
                      dir_tab[i].heading, dir_tab[i].speed);
        end

        phase = 0;
        while (items < TARGET_ITEMS) begin
            if (phase % 3 == 0) begin
                wait_idle();
                set_reg(pps_pkg::REG_LOOKAHEAD, ($urandom_range(0, 2) == 0) ? pick(8388607)
                                                                             : pick(12000));
                set_reg(pps_pkg::REG_MAX_STEER, pick(25736));
                set_reg(pps_pkg::REG_TOP_SPEED, pick(65535));
                set_reg(pps_pkg::REG_ANG_GAIN, pick(65535));
                set_reg(pps_pkg::REG_DST_GAIN, pick(65535));
                set_reg(pps_pkg::REG_IDX_RATE,
                        ($urandom_range(0, 1) == 0) ? pick(65535) : pick(1024));
            end
            phase++;
            wide = ($urandom_range(0, 4) == 0);
            if (big_cnt < 6 && $urandom_range(0, 24) == 0) begin
                big_cnt++;
                n = $urandom_range(120, 135);
            end else begin
                n = $urandom_range(1, 10);
            end
            step = $urandom_range(1, 4000);
            cx = longint'($urandom_range(0, 4194304)) - 2097152;
            cy = longint'($urandom_range(0, 4194304)) - 2097152;
            for (int i = 0; i < n; i++) begin
                if (wide) begin
                    qx = $urandom; qy = $urandom;
                end else begin
                    cx = cx + $urandom_range(0, 2 * step) - step;
                    cy = cy + $urandom_range(0, 2 * step) - step;
                    qx = cx[23:0]; qy = cy[23:0];
                end
                send_word(0, i == 0, qx, qy, $urandom, $urandom);
            end
            q = (n > DEPTH / 2) ? 3 : $urandom_range(2, 6);
            for (int j = 0; j < q; j++) begin
                if ($urandom_range(0, 9) == 0)
                    send_word(0, $urandom_range(0, 7) == 0, $urandom, $urandom, 0, 0);
                k = $urandom_range(0, path_len - 1);
                off = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(0, 16000);
                if (wide && $urandom_range(0, 1) == 0) begin
                    qx = $urandom; qy = $urandom;
                end else begin
                    qx = path_x[k] + $urandom_range(0, 2 * off) - off;
                    qy = path_y[k] + $urandom_range(0, 2 * off) - off;
                end
                case ($urandom_range(0, 7)) inside
                    0:       spd = 16'hFFFF;
                    1:       spd = 16'h0000;
                    [2:3]:   spd = $urandom_range(0, 2048);
                    default: spd = $urandom;
                endcase
                send_word(1, $urandom_range(0, 1), qx, qy, $urandom, spd);
            end
        end

        wait_idle();
        repeat (100) @(negedge i_clk);
        if (err_cnt == 0 && steer_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
